@@ hdl/atc_pkg.sv @@
package atc_pkg;

    localparam int WINDOW_CHARS_DEFAULT = 8;
    localparam int NUM_PUNCT = 10;
    localparam int NUM_KEYS = 53;
    localparam int KEY_IDX_W = $clog2(NUM_KEYS);

    localparam logic [6:0] KIND_UNKNOWN = 7'd0;
    localparam logic [6:0] KIND_HEX = 7'd1;
    localparam logic [6:0] KIND_BIN = 7'd2;
    localparam logic [6:0] KIND_DEC = 7'd3;
    localparam logic [6:0] KIND_PUNCT0 = 7'd4;
    localparam logic [6:0] KIND_ACCU = 7'd14;
    localparam logic [6:0] KIND_REG0 = 7'd15;
    localparam logic [6:0] KIND_KEY0 = 7'd23;
    localparam logic [6:0] KIND_IDENT = 7'd76;

    typedef struct packed {
        logic [7:0] char_0;
        logic [7:0] char_1;
        logic [7:0] char_2;
        logic [7:0] char_3;
        logic [7:0] char_4;
        logic [7:0] char_5;
        logic [7:0] char_6;
        logic [7:0] char_7;
        logic [3:0] valid_count;
    } atc_in_t;

    typedef struct packed {
        logic [6:0] token_kind;
        logic [3:0] token_length;
        logic       window_overrun;
    } atc_out_t;

    typedef logic [7:0][7:0] atc_window_t;

    typedef struct packed {
        logic                 hit;
        logic [KEY_IDX_W-1:0] index;
        logic [3:0]           length;
    } atc_key_hit_t;

    localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
        8'h0a, 8'h20, 8'h2c, 8'h24, 8'h2f, 8'h2b, 8'h2e, 8'h3a, 8'h3b, 8'h23
    };

    // keyword text with its trailing space, right-justified, first char in the top used byte
    localparam logic [63:0] KEY_TEXT [NUM_KEYS] = '{
        64'("nop "), 64'("jbc "), 64'("jb "), 64'("jnb "), 64'("jc "),
        64'("jnc "), 64'("jz "), 64'("jnz "), 64'("sjmp "), 64'("mov "),
        64'("orl "), 64'("anl "), 64'("push "), 64'("pop "), 64'("movx "),
        64'("ajmp "), 64'("acall "), 64'("ljmp "), 64'("lcall "), 64'("reti "),
        64'("ret "), 64'("xrl "), 64'("cpl "), 64'("clr "), 64'("setb "),
        64'("rr "), 64'("rrc "), 64'("rl "), 64'("rlc "), 64'("xlr "),
        64'("jmp "), 64'("movc "), 64'("inc "), 64'("dec "), 64'("add "),
        64'("addc "), 64'("div "), 64'("dubb "), 64'("mul "), 64'("cjne "),
        64'("swap "), 64'("da "), 64'("crl "), 64'("xch "), 64'("djnz "),
        64'("xchd "), 64'("call "), 64'("org "), 64'("db "), 64'("dw "),
        64'("data "), 64'("bit "), 64'("include ")
    };

    function automatic int key_size(input logic [63:0] text);
        int n;
        n = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (text[8*i +: 8] != 8'h00)
            begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;
    endfunction

endpackage

@@ hdl/atc_keyword_match.sv @@
module atc_keyword_match (
    input  atc_pkg::atc_window_t  folded,
    input  logic [3:0]            valid_count,
    output atc_pkg::atc_key_hit_t key_hit
);
    import atc_pkg::*;

    logic [NUM_KEYS-1:0] hits;

    function automatic logic key_match(
        input atc_window_t chars,
        input logic [3:0]  count,
        input logic [63:0] text
    );
        int   sz;
        logic ok;
        sz = key_size(text);
        ok = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if ((i < sz) && (4'(i) < count) && (chars[i] != text[8*(sz-1-i) +: 8]))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        assign hits[k] = key_match(folded, valid_count, KEY_TEXT[k]);
    end

    // first table entry wins
    always_comb
    begin
        key_hit = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (hits[k])
            begin
                key_hit.hit    = 1'b1;
                key_hit.index  = KEY_IDX_W'(k);
                key_hit.length = 4'(key_size(KEY_TEXT[k]) - 1);
            end
        end
    end

endmodule

@@ hdl/atc_classify.sv @@
module atc_classify #(
    parameter int WINDOW_CHARS = atc_pkg::WINDOW_CHARS_DEFAULT
) (
    input  atc_pkg::atc_in_t  req,
    output atc_pkg::atc_out_t result
);
    import atc_pkg::*;

    atc_window_t  w;
    atc_window_t  wf;
    atc_key_hit_t key_hit;
    logic [3:0]   hex_run;
    logic [3:0]   id_run;
    logic [7:0]   num_next;
    logic [7:0]   num_last;
    logic         punct_hit;
    logic [3:0]   punct_idx;
    logic         reg_hit;
    logic [2:0]   reg_idx;
    logic         accu_hit;

    assign w[0] = req.char_0;
    assign w[1] = req.char_1;
    assign w[2] = req.char_2;
    assign w[3] = req.char_3;
    assign w[4] = req.char_4;
    assign w[5] = req.char_5;
    assign w[6] = req.char_6;
    assign w[7] = req.char_7;

    for (genvar i = 0; i < 8; i++)
    begin : g_fold
        assign wf[i] = fold(w[i]);
    end

    atc_keyword_match u_keys (
        .folded      (wf),
        .valid_count (req.valid_count),
        .key_hit     (key_hit)
    );

    // run lengths: index of the first character that breaks the run
    always_comb
    begin
        hex_run = 4'd8;
        id_run  = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (!is_hex(w[i]))
            begin
                hex_run = 4'(i);
            end
            if (!(is_alpha(w[i]) || is_digit(w[i])))
            begin
                id_run = 4'(i);
            end
        end
    end

    // positions past the inputs read as zero
    assign num_next = hex_run[3] ? 8'h00 : w[hex_run[2:0]];
    assign num_last = w[3'(hex_run - 4'd1)];

    always_comb
    begin
        punct_hit = 1'b0;
        punct_idx = '0;
        for (int i = NUM_PUNCT - 1; i >= 0; i--)
        begin
            if (w[0] == PUNCT_CHARS[i])
            begin
                punct_hit = 1'b1;
                punct_idx = 4'(i);
            end
        end
    end

    assign accu_hit = (w[0] == "A") && !is_alpha(w[1]);

    always_comb
    begin
        reg_hit = 1'b0;
        reg_idx = '0;
        for (int r = 7; r >= 0; r--)
        begin
            if (((req.valid_count == 4'd0) || (wf[0] == "r")) &&
                ((req.valid_count < 4'd2) || (wf[1] == (8'h30 + 8'(r)))) &&
                !is_alpha(w[2]))
            begin
                reg_hit = 1'b1;
                reg_idx = 3'(r);
            end
        end
    end

    always_comb
    begin
        result = '0;
        if (is_digit(w[0]))
        begin
            result.window_overrun = ({1'b0, hex_run} >= 5'(WINDOW_CHARS));
            if ((num_next == "h") || (num_next == "H"))
            begin
                result.token_kind   = KIND_HEX;
                result.token_length = hex_run + 4'd1;
            end
            else if ((num_last == "b") || (num_last == "B"))
            begin
                result.token_kind   = KIND_BIN;
                result.token_length = hex_run;
            end
            else
            begin
                result.token_kind   = KIND_DEC;
                result.token_length = hex_run;
            end
        end
        else if (punct_hit)
        begin
            result.token_kind   = KIND_PUNCT0 + 7'(punct_idx);
            result.token_length = 4'd1;
        end
        else if (accu_hit)
        begin
            result.token_kind   = KIND_ACCU;
            result.token_length = 4'd1;
        end
        else if (reg_hit)
        begin
            result.token_kind   = KIND_REG0 + 7'(reg_idx);
            result.token_length = 4'd2;
        end
        else if (key_hit.hit)
        begin
            result.token_kind   = KIND_KEY0 + 7'(key_hit.index);
            result.token_length = key_hit.length;
        end
        else if (is_alpha(w[0]))
        begin
            result.token_kind     = KIND_IDENT;
            result.token_length   = id_run + 4'd1;
            result.window_overrun = ({1'b0, id_run} >= 5'(WINDOW_CHARS));
        end
    end

endmodule

@@ hdl/asm_token_classifier_unit.sv @@
// Assembler token classifier.
// A request carries an 8-character text window and the remaining text
// length; the response gives the kind and length of the window's first
// token plus a flag for a run that reached the window end.
// Both channels are valid/ready; a request is taken when req_valid and
// req_ready are high at a clock edge, a response when rsp_valid and
// rsp_ready are.
// Two register stages: the request register feeds the classifier logic,
// whose result lands in the response register. A staged request moves
// into the response register when that register is empty or being read.
// Throughput is one request per cycle while rsp_ready stays high; the
// request register and the response register each hold one item.
// While rsp_ready is low the response holds, and the request stage still
// takes one more request before req_ready drops.
// rst_n (asynchronous, active low) empties both stages.
module asm_token_classifier_unit #(
    parameter int WINDOW_CHARS = atc_pkg::WINDOW_CHARS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  atc_pkg::atc_in_t  req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output atc_pkg::atc_out_t rsp_data
);
    import atc_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    atc_in_t  s1_data_reg;
    atc_in_t  s1_data_next;
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    atc_out_t rsp_data_reg;
    atc_out_t rsp_data_next;
    atc_out_t cls_result;
    logic     s2_ready;

    atc_classify #(
        .WINDOW_CHARS (WINDOW_CHARS)
    ) u_classify (
        .req    (s1_data_reg),
        .result (cls_result)
    );

    assign s2_ready  = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || s2_ready;

    always_comb
    begin
        s1_valid_next  = req_ready ? req_valid : s1_valid_reg;
        s1_data_next   = (req_valid && req_ready) ? req_data : s1_data_reg;
        rsp_valid_next = s2_ready ? s1_valid_reg : rsp_valid_reg;
        rsp_data_next  = (s2_ready && s1_valid_reg) ? cls_result : rsp_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> rsp_valid_reg)
        else $error("staged request did not reach the response register");

    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_data_reg.token_kind == KIND_UNKNOWN)) |->
        ((rsp_data_reg.token_length == 4'd0) && !rsp_data_reg.window_overrun))
        else $error("unknown token with nonzero length or overrun");

    a_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.window_overrun) |->
        (((rsp_data_reg.token_kind == KIND_HEX) || (rsp_data_reg.token_kind == KIND_BIN) ||
          (rsp_data_reg.token_kind == KIND_DEC) || (rsp_data_reg.token_kind == KIND_IDENT)) &&
         (rsp_data_reg.token_length >= 4'd8)))
        else $error("overrun flagged on a token without a full-window run");

    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_data_reg.token_kind == KIND_IDENT)) |->
        (rsp_data_reg.token_length >= 4'd2))
        else $error("identifier length below run plus one");

endmodule
